// ===== hdl/rlm_pkg.sv =====
// ---------------------------------------------------------------------------
// rlm_pkg
// Shared widths, register codes and reset values of the RMS level meter.
// ---------------------------------------------------------------------------
`default_nettype none

package rlm_pkg;

    // sample format and channel layout
    localparam int SAMPLE_BITS    = 16;
    localparam int PROD_W         = 2 * SAMPLE_BITS;
    localparam int SQ_W           = 2 * SAMPLE_BITS - 1;
    localparam int MAX_CHANNELS   = 8;
    localparam int CH_W           = $clog2(MAX_CHANNELS);
    localparam int NCH_W          = $clog2(MAX_CHANNELS + 1);
    localparam int MAX_FRAMES_DEF = 4096;

    // smoothing
    localparam int W_W    = 17;
    localparam int W_FRAC = 16;
    localparam int W_ONE  = 1 << W_FRAC;
    localparam int SM_W   = 32;
    localparam int ACC_W  = SM_W + W_FRAC;
    localparam int LVL_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = W_W;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = CFG_IDX_W'(1);

    localparam logic [NCH_W-1:0] NCH_RESET = NCH_W'(2);
    localparam logic [W_W-1:0]   W_RESET   = W_W'(4588);

endpackage

`default_nettype wire

// ===== hdl/rlm_ifs.sv =====
// ---------------------------------------------------------------------------
// rlm_ifs
// Valid/ready channels of the level meter: samples in, levels out, config.
// ---------------------------------------------------------------------------
`default_nettype none

interface rlm_in_if
    import rlm_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          buffer_end;

    modport source (output valid, sample, buffer_end, input ready);
    modport sink   (input valid, sample, buffer_end, output ready);
endinterface

interface rlm_out_if
    import rlm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel;
    logic [LVL_W-1:0] rms_level;
    logic [LVL_W-1:0] smoothed_level;
    logic             overflow;
    logic             last_result;

    modport source (output valid, channel, rms_level, smoothed_level, overflow,
                    last_result, input ready);
    modport sink   (input valid, channel, rms_level, smoothed_level, overflow,
                    last_result, output ready);
endinterface

interface rlm_cfg_if
    import rlm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rlm_div.sv =====
// ---------------------------------------------------------------------------
// rlm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rlm_div
    import rlm_pkg::*;
#(
    parameter int DVD_W = SQ_W + $clog2(MAX_FRAMES_DEF + 1),
    parameter int DVS_W = $clog2(MAX_FRAMES_DEF + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;   // dividend shifts out, quotient shifts in
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

// ===== hdl/rlm_sqrt.sv =====
// ---------------------------------------------------------------------------
// rlm_sqrt
// Digit-serial integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rlm_sqrt
    import rlm_pkg::*;
#(
    parameter int RAD_W = SQ_W + $clog2(MAX_FRAMES_DEF + 1),
    parameter int RT_W  = (RAD_W + 1) / 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [RAD_W-1:0] radicand,
    output logic                  done,
    output logic [RT_W-1:0]       root
);

    localparam int PAD_W = 2 * RT_W;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PAD_W-1:0] val_reg, val_next;
    logic [RT_W:0]    rem_reg, rem_next;
    logic [RT_W-1:0]  root_reg, root_next;

    logic [RT_W+2:0] trial_rem;
    logic [RT_W+2:0] trial;
    logic [RT_W+2:0] diff;
    logic            ge;

    assign trial_rem = {rem_reg, val_reg[PAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign ge        = (trial_rem >= trial);
    assign diff      = trial_rem - trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(RT_W);
            val_next  = PAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next  = {val_reg[PAD_W-3:0], 2'b00};
            rem_next  = ge ? diff[RT_W:0] : trial_rem[RT_W:0];
            root_next = {root_reg[RT_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/rlm_ema.sv =====
// ---------------------------------------------------------------------------
// rlm_ema
// Exponential smoothing step, weight applied one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module rlm_ema
    import rlm_pkg::*;
#(
    parameter int RT_W = (SQ_W + $clog2(MAX_FRAMES_DEF + 1) + 1) / 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [SM_W-1:0] level,
    input  wire logic [RT_W-1:0] rms,
    input  wire logic [W_W-1:0]  weight,
    output logic                 done,
    output logic [SM_W-1:0]      level_new
);

    // s' = (s*2^16 + ((rms << 16) - s) * w) >> 16; only bits up to ACC_W
    // matter, so the whole sum is kept modulo 2^ACC_W.
    localparam int CNT_W = $clog2(W_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] step_reg, step_next;
    logic [W_W-1:0]   w_reg, w_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        w_next    = w_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W_W);
            acc_next  = {level, W_FRAC'(0)};
            step_next = (ACC_W'(rms) << W_FRAC) - ACC_W'(level);
            w_next    = weight;
        end
        else if (busy_reg)
        begin
            if (w_reg[0])
            begin
                acc_next = acc_reg + step_reg;
            end
            step_next = {step_reg[ACC_W-2:0], 1'b0};
            w_next    = {1'b0, w_reg[W_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        step_reg <= step_next;
        w_reg    <= w_next;
    end

    assign done      = done_reg;
    assign level_new = acc_reg[ACC_W-1:W_FRAC];

endmodule

`default_nettype wire

// ===== hdl/per_channel_rms_level_meter_unit.sv =====
// ---------------------------------------------------------------------------
// per_channel_rms_level_meter_unit
// Interleaved Q1.15 samples come in one request at a time; each sample's
// square is added to the sum of its channel. A sample flagged buffer_end
// closes the buffer: for every channel in turn the block divides the sum by
// the frame count, takes the square root (rms_level) and folds it into that
// channel's exponentially smoothed level with the Q16 weight smooth_weight.
// One result request per channel follows, last_result on the final one, and
// overflow reports samples dropped once MAX_FRAMES frames were counted.
// A sample is taken in ST_IDLE and added into its channel sum in ST_ACC.
// Closing a buffer runs, for each channel in turn, the bit-serial divider,
// the two-bit-a-cycle square root and the bit-serial weight multiply, which
// run one after the other. No sample is taken while a buffer is being
// closed; the next one is taken as soon as the last result has gone into
// the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module per_channel_rms_level_meter_unit
    import rlm_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rlm_cfg_if.sink    cfg,
    rlm_in_if.sink     samples,
    rlm_out_if.source  levels
);

    localparam int FCNT_W = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W  = SQ_W + FCNT_W;
    localparam int RT_W   = (SUM_W + 1) / 2;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;   // waiting for a sample
    localparam logic [2:0] ST_ACC   = 3'd1;   // add square into channel sum
    localparam logic [2:0] ST_START = 3'd2;   // kick off divider for ch_reg
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SQRT  = 3'd4;
    localparam logic [2:0] ST_EMA   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;   // hand result to output register

    // configuration
    logic [NCH_W-1:0] nch_cfg_reg;
    logic [W_W-1:0]   w_cfg_reg;
    logic [NCH_W-1:0] nch_eff;
    logic [W_W-1:0]   w_eff;

    // control state
    logic [2:0]        state_reg, state_next;
    logic [CH_W-1:0]   pos_reg, pos_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic              ovf_reg, ovf_next;
    logic [CH_W-1:0]   acc_ch_reg, acc_ch_next;
    logic              acc_en_reg, acc_en_next;
    logic              end_reg, end_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              out_vld_reg, out_vld_next;

    // payload
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [FCNT_W-1:0] frames_reg, frames_next;
    logic [W_W-1:0]    wgt_reg, wgt_next;
    logic [CH_W-1:0]   out_ch_reg, out_ch_next;
    logic [LVL_W-1:0]  out_rms_reg, out_rms_next;
    logic [LVL_W-1:0]  out_sm_reg, out_sm_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_last_reg, out_last_next;

    // per-channel stores; entries not marked valid read as zero
    logic [SUM_W-1:0]        sums_reg [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] sum_vld_reg, sum_vld_next;
    logic [SM_W-1:0]         sm_lvl_reg [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] sm_vld_reg, sm_vld_next;

    logic             sum_we;
    logic [SUM_W-1:0] sum_wdata;
    logic [CH_W-1:0]  sum_rd_idx;
    logic [SUM_W-1:0] sum_rd;
    logic [SM_W-1:0]  sm_rd;
    logic             sm_we;

    // sample path
    logic                   take;
    logic [SAMPLE_BITS-1:0] mag;
    logic [PROD_W-1:0]      prod;
    logic [CH_W-1:0]        pos_eff;
    logic                   room;
    logic                   frame_done;

    // finish path
    logic              partial;
    logic [FCNT_W-1:0] frames_sum;
    logic              slot_free;
    logic              is_last;

    // serial units
    logic             div_start, div_done;
    logic [SUM_W-1:0] quotient;
    logic             sqrt_start, sqrt_done;
    logic [RT_W-1:0]  root;
    logic             ema_start, ema_done;
    logic [SM_W-1:0]  level_new;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch_cfg_reg <= NCH_RESET;
            w_cfg_reg   <= W_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_NUM_CHANNELS:  nch_cfg_reg <= cfg.data[NCH_W-1:0];
                REG_SMOOTH_WEIGHT: w_cfg_reg   <= cfg.data[W_W-1:0];
                default:           ;
            endcase
        end
    end

    // zero counts as one channel, anything above the store depth as full depth
    assign nch_eff = (nch_cfg_reg == '0) ? NCH_W'(1) :
                     (nch_cfg_reg > NCH_W'(MAX_CHANNELS)) ? NCH_W'(MAX_CHANNELS) :
                     nch_cfg_reg;
    assign w_eff   = (w_cfg_reg > W_W'(W_ONE)) ? W_W'(W_ONE) : w_cfg_reg;

    // ----------------------------------------------------------- sample path
    assign samples.ready = (state_reg == ST_IDLE);
    assign take          = samples.valid && samples.ready;

    // most negative code maps to +2^(SAMPLE_BITS-1), which the unsigned view keeps
    assign mag  = samples.sample[SAMPLE_BITS-1] ? (~samples.sample + 1'b1)
                                                : samples.sample;
    assign prod = PROD_W'(mag) * PROD_W'(mag);

    // a channel count lowered mid-frame restarts the frame without counting it
    assign pos_eff    = (NCH_W'(pos_reg) >= nch_eff) ? '0 : pos_reg;
    assign room       = (fcnt_reg < FCNT_W'(MAX_FRAMES));
    assign frame_done = ((NCH_W'(pos_eff) + 1'b1) >= nch_eff);

    // ---------------------------------------------------------------- stores
    assign sum_rd_idx = (state_reg == ST_ACC) ? acc_ch_reg : ch_reg;
    assign sum_rd     = sum_vld_reg[sum_rd_idx] ? sums_reg[sum_rd_idx] : '0;
    assign sm_rd      = sm_vld_reg[ch_reg] ? sm_lvl_reg[ch_reg] : '0;
    assign sum_we     = (state_reg == ST_ACC) && acc_en_reg;
    assign sum_wdata  = sum_rd + SUM_W'(sq_reg);

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sums_reg[acc_ch_reg] <= sum_wdata;
        end
        if (sm_we)
        begin
            sm_lvl_reg[ch_reg] <= level_new;
        end
    end

    // ----------------------------------------------------------- finish path
    // a started frame counts once, if its samples were taken
    assign partial    = (pos_reg != '0) && room;
    assign frames_sum = fcnt_reg + FCNT_W'(partial);
    assign slot_free  = !out_vld_reg || levels.ready;
    assign is_last    = ((NCH_W'(ch_reg) + 1'b1) == nch_eff);

    assign div_start  = (state_reg == ST_START);
    assign sqrt_start = (state_reg == ST_DIV) && div_done;
    assign ema_start  = (state_reg == ST_SQRT) && sqrt_done;
    assign sm_we      = (state_reg == ST_EMIT) && slot_free;

    rlm_div #(
        .DVD_W (SUM_W),
        .DVS_W (FCNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_rd),
        .divisor  (frames_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    rlm_sqrt #(
        .RAD_W (SUM_W),
        .RT_W  (RT_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (quotient),
        .done     (sqrt_done),
        .root     (root)
    );

    rlm_ema #(
        .RT_W (RT_W)
    ) u_ema (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ema_start),
        .level     (sm_rd),
        .rms       (root),
        .weight    (wgt_reg),
        .done      (ema_done),
        .level_new (level_new)
    );

    // ------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        fcnt_next     = fcnt_reg;
        ovf_next      = ovf_reg;
        acc_ch_next   = acc_ch_reg;
        acc_en_next   = acc_en_reg;
        end_next      = end_reg;
        ch_next       = ch_reg;
        sq_next       = sq_reg;
        frames_next   = frames_reg;
        wgt_next      = wgt_reg;
        sum_vld_next  = sum_vld_reg;
        sm_vld_next   = sm_vld_reg;
        out_vld_next  = out_vld_reg && !levels.ready;
        out_ch_next   = out_ch_reg;
        out_rms_next  = out_rms_reg;
        out_sm_next   = out_sm_reg;
        out_ovf_next  = out_ovf_reg;
        out_last_next = out_last_reg;

        if (sum_we)
        begin
            sum_vld_next[acc_ch_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    sq_next     = sq_reg;
                    sq_next     = prod[SQ_W-1:0];
                    acc_ch_next = pos_eff;
                    acc_en_next = room;
                    end_next    = samples.buffer_end;
                    pos_next    = frame_done ? '0 : (pos_eff + 1'b1);
                    if (room && frame_done)
                    begin
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                    if (!room)
                    begin
                        ovf_next = 1'b1;
                    end
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (end_reg)
                begin
                    frames_next = (frames_sum == '0) ? FCNT_W'(1) : frames_sum;
                    wgt_next    = w_eff;
                    ch_next     = '0;
                    state_next  = ST_START;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = ST_EMA;
                end
            end
            ST_EMA:
            begin
                if (ema_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    sm_vld_next[ch_reg] = 1'b1;
                    out_vld_next  = 1'b1;
                    out_ch_next   = ch_reg;
                    out_rms_next  = root[LVL_W-1:0];
                    out_sm_next   = level_new[SM_W-1 -: LVL_W];
                    out_ovf_next  = ovf_reg;
                    out_last_next = is_last;
                    if (is_last)
                    begin
                        // start a fresh buffer
                        sum_vld_next = '0;
                        fcnt_next    = '0;
                        pos_next     = '0;
                        ovf_next     = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            fcnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            acc_ch_reg  <= '0;
            acc_en_reg  <= 1'b0;
            end_reg     <= 1'b0;
            ch_reg      <= '0;
            frames_reg  <= FCNT_W'(1);
            sum_vld_reg <= '0;
            sm_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            fcnt_reg    <= fcnt_next;
            ovf_reg     <= ovf_next;
            acc_ch_reg  <= acc_ch_next;
            acc_en_reg  <= acc_en_next;
            end_reg     <= end_next;
            ch_reg      <= ch_next;
            frames_reg  <= frames_next;
            sum_vld_reg <= sum_vld_next;
            sm_vld_reg  <= sm_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg       <= sq_next;
        wgt_reg      <= wgt_next;
        out_ch_reg   <= out_ch_next;
        out_rms_reg  <= out_rms_next;
        out_sm_reg   <= out_sm_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign levels.valid          = out_vld_reg;
    assign levels.channel        = out_ch_reg;
    assign levels.rms_level      = out_rms_reg;
    assign levels.smoothed_level = out_sm_reg;
    assign levels.overflow       = out_ovf_reg;
    assign levels.last_result    = out_last_reg;

    // ------------------------------------------------------------ assertions
    a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FCNT_W'(MAX_FRAMES))
        else $error("frame count beyond MAX_FRAMES");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |-> (frames_reg != '0))
        else $error("zero frame count handed to divider");

    a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START) |-> (NCH_W'(ch_reg) < nch_eff))
        else $error("result channel beyond channel count");

    a_buffer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && is_last) |=>
            (fcnt_reg == '0 && pos_reg == '0 && sum_vld_reg == '0 && !ovf_reg))
        else $error("accumulators not cleared after last result");

endmodule

`default_nettype wire

// ===== tb/per_channel_rms_level_meter_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// per_channel_rms_level_meter_unit_tb
// Self-checking bench for the per-channel RMS level meter. Sample, level and
// register write requests run over valid/ready channels with random gaps on
// both sides. A behavioural level model in the bench predicts every level
// result; a checker compares each accepted result with the oldest one due.
// ---------------------------------------------------------------------------

module per_channel_rms_level_meter_unit_tb;
    import rlm_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    // a sample is taken, then added into its channel sum in ST_ACC; allow a margin
    localparam int SETTLE_CYCLES  = 6;
    // closing an 8 channel buffer runs the serial units once per channel
    localparam int TAIL_CYCLES    = 200;
    // longest correct quiet spell is one channel close plus a short
    // receiver stall, or the settle and tail waits; taken well over
    localparam int STALL_LIMIT    = 3000;
    localparam int IDLE_PCT       = 7;
    localparam int RANDOM_SAMPLES = 180;
    localparam int MAX_REPORTS    = 10;

    // an index that selects no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [LVL_W-1:0] rms;
        logic [LVL_W-1:0] smooth;
        logic             ovf;
        logic             last;
    } level_t;

    logic clk;
    logic rst_n;

    rlm_cfg_if cfg_bus ();
    rlm_in_if  sample_bus ();
    rlm_out_if level_bus ();

    per_channel_rms_level_meter_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .samples (sample_bus),
        .levels  (level_bus)
    );

    // -----------------------------------------------------------------------
    // Level model state: its own copy of the registers and accumulators
    // -----------------------------------------------------------------------
    logic [NCH_W-1:0] mdl_nch_reg;
    logic [W_W-1:0]   mdl_weight_reg;
    u64_t             chan_energy [MAX_CHANNELS];
    u64_t             chan_smooth [MAX_CHANNELS];
    int               frames_done;
    int               chan_pos;
    logic             dropped;

    level_t pending_levels [$];

    int err_count = 0;
    int n_samples = 0;
    int n_buffers = 0;
    int n_levels  = 0;
    int n_writes  = 0;
    int stall_cycles = 0;
    bit steady = 1'b0;     // set: neither side idles

    // clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    // bit-pair integer square root, floor
    function automatic u64_t int_sqrt(input u64_t v);
        u64_t root;
        u64_t probe;
        root  = 0;
        probe = u64_t'(1) << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // channel count the block works with: 0 acts as 1, above 8 acts as 8
    function automatic int active_channels();
        int n;
        n = int'(mdl_nch_reg);
        if (n < 1)
            n = 1;
        if (n > MAX_CHANNELS)
            n = MAX_CHANNELS;
        return n;
    endfunction

    function automatic void clear_buffer();
        for (int i = 0; i < MAX_CHANNELS; i++)
            chan_energy[i] = 0;
        frames_done = 0;
        chan_pos    = 0;
        dropped     = 1'b0;
    endfunction

    function automatic void meter_reset();
        mdl_nch_reg    = NCH_RESET;
        mdl_weight_reg = W_RESET;
        for (int i = 0; i < MAX_CHANNELS; i++)
            chan_smooth[i] = 0;
        clear_buffer();
    endfunction

    // Accumulate one accepted sample; at buffer end queue one level per channel
    function automatic void meter_predict(input logic signed [SAMPLE_BITS-1:0] s,
                                          input logic last);
        int     nch;
        int     mag;
        int     frames;
        int     w;
        u64_t   mean;
        u64_t   rms;
        u64_t   acc;
        level_t lv;
        nch = active_channels();
        mag = (s < 0) ? -int'(s) : int'(s);

        // channel count shrunk under a half-done frame: restart the frame
        if (chan_pos >= nch)
            chan_pos = 0;

        if (frames_done < MAX_FRAMES_DEF)
        begin
            chan_energy[chan_pos] += u64_t'(mag) * u64_t'(mag);
            if (chan_pos + 1 >= nch)
                frames_done++;
        end
        else
            dropped = 1'b1;
        chan_pos++;
        if (chan_pos >= nch)
            chan_pos = 0;

        if (last)
        begin
            // a partial last frame counts once, unless the buffer is full
            frames = frames_done +
                     ((chan_pos != 0 && frames_done < MAX_FRAMES_DEF) ? 1 : 0);
            if (frames == 0)
                frames = 1;
            w = (mdl_weight_reg > W_ONE) ? W_ONE : int'(mdl_weight_reg);

            for (int ch = 0; ch < nch; ch++)
            begin
                mean = chan_energy[ch] / u64_t'(frames);
                rms  = int_sqrt(mean);
                acc  = (chan_smooth[ch] * u64_t'(W_ONE - w) +
                        (rms << W_FRAC) * u64_t'(w)) >> W_FRAC;
                chan_smooth[ch] = acc & 64'hFFFF_FFFF;
                lv.channel = CH_W'(ch);
                lv.rms     = rms[LVL_W-1:0];
                lv.smooth  = chan_smooth[ch][31:16];
                lv.ovf     = dropped;
                lv.last    = (ch + 1 == nch);
                pending_levels.push_back(lv);
            end
            clear_buffer();
        end
    endfunction

    // -----------------------------------------------------------------------
    // Request drivers: entered and left at a falling edge
    // -----------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_NUM_CHANNELS:  mdl_nch_reg    = val[NCH_W-1:0];
            REG_SMOOTH_WEIGHT: mdl_weight_reg = val[W_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s,
                               input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            sample_bus.valid = 1'b0;
            @(negedge clk);
        end
        sample_bus.valid      = 1'b1;
        sample_bus.sample     = s;
        sample_bus.buffer_end = last;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        meter_predict(s, last);
        n_samples++;
        if (last)
            n_buffers++;
        @(negedge clk);
        sample_bus.valid = 1'b0;
    endtask

    // Hold off samples until every level due has come, then let the last
    // sample finish its add so register writes land on an idle block
    task automatic settle();
        sample_bus.valid = 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            3:       return SAMPLE_BITS'($urandom_range(0, 255));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // channel count write: mostly 1..8, sometimes out of range; junk above
    function automatic logic [CFG_DATA_W-1:0] rand_nch_word();
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        v[NCH_W-1:0] = ($urandom_range(3) == 0) ? NCH_W'($urandom_range(0, 15))
                                                : NCH_W'($urandom_range(1, 8));
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_weight_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_DATA_W'(W_ONE);
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, W_ONE));
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Level checker: compares each accepted result with the oldest prediction
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : level_check
        level_t got;
        level_t want;
        if (rst_n && level_bus.valid && level_bus.ready)
        begin
            got.channel = level_bus.channel;
            got.rms     = level_bus.rms_level;
            got.smooth  = level_bus.smoothed_level;
            got.ovf     = level_bus.overflow;
            got.last    = level_bus.last_result;
            n_levels++;
            if (pending_levels.size() == 0)
                note_error($sformatf("unexpected level: ch %0d rms %0d smooth %0d",
                                     got.channel, got.rms, got.smooth));
            else
            begin
                want = pending_levels.pop_front();
                if (got.channel !== want.channel || got.rms !== want.rms ||
                    got.smooth !== want.smooth || got.ovf !== want.ovf ||
                    got.last !== want.last)
                    note_error($sformatf({"level mismatch: expected ch %0d rms %0d ",
                                          "smooth %0d ovf %0b last %0b, got ch %0d ",
                                          "rms %0d smooth %0d ovf %0b last %0b"},
                                         want.channel, want.rms, want.smooth,
                                         want.ovf, want.last, got.channel, got.rms,
                                         got.smooth, got.ovf, got.last));
            end
        end
    end

    // receiver back-pressure, changed at the falling edge
    always @(negedge clk)
        level_bus.ready = steady || ($urandom_range(99) >= IDLE_PCT);

    // watchdog: too long without any request going through on any channel
    always @(posedge clk)
    begin
        if ((cfg_bus.valid && cfg_bus.ready) ||
            (sample_bus.valid && sample_bus.ready) ||
            (level_bus.valid && level_bus.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // reset settings: two channels, weight about 0.07; sample extremes
    task automatic test_reset_defaults();
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh0000, 1'b0);
        push_sample(-16'sd1, 1'b1);
        settle();
    endtask

    task automatic test_channel_counts();
        // one channel, buffer of a single sample
        write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(1));
        push_sample(16'sd1, 1'b1);
        settle();
        // zero acts as one; junk in the upper data bits is ignored
        write_reg(REG_NUM_CHANNELS, 17'h1FFF0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b1);
        settle();
        // full eight channels, one frame
        write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(MAX_CHANNELS));
        for (int k = 0; k < MAX_CHANNELS; k++)
            push_sample(rand_sample(), k == MAX_CHANNELS - 1);
        settle();
        // fifteen acts as eight; buffer ends after three channels of a frame,
        // the channels missing from it are divided by the same count
        write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(15));
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh4000, 1'b0);
        push_sample(16'sh7FFF, 1'b1);
        settle();
    endtask

    task automatic test_frame_restart();
        // three channels, two samples in, then the count drops to two: the
        // position is past the new count and the frame starts over
        write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(3));
        push_sample(16'sh1234, 1'b0);
        push_sample(-16'sd300, 1'b0);
        settle();
        write_reg(REG_NUM_CHANNELS, CFG_DATA_W'(2));
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        push_sample(16'sh7FFF, 1'b1);
        settle();
    endtask

    task automatic test_weights();
        // zero holds the smoothed level, one copies the RMS, above one clamps
        write_reg(REG_SMOOTH_WEIGHT, '0);
        push_sample(16'sh2000, 1'b0);
        push_sample(16'sh8000, 1'b1);
        settle();
        write_reg(REG_SMOOTH_WEIGHT, CFG_DATA_W'(W_ONE));
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh0100, 1'b1);
        settle();
        write_reg(REG_SMOOTH_WEIGHT, '1);
        push_sample(-16'sd12345, 1'b0);
        push_sample(16'sd1, 1'b1);
        settle();
    endtask

    // mostly whole-frame buffers with random content; some end mid-frame,
    // some change the channel count under a half-done frame
    task automatic test_random_buffers();
        int  left;
        int  len;
        bit  swap;
        left = RANDOM_SAMPLES;
        while (left > 0)
        begin
            // a stretch in the middle runs with no idling on either side
            steady = (left <= 110 && left > 50);
            if ($urandom_range(2) == 0)
            begin
                settle();
                if ($urandom_range(1) == 0)
                    write_reg(REG_NUM_CHANNELS, rand_nch_word());
                else
                    write_reg(REG_SMOOTH_WEIGHT, rand_weight_word());
            end
            len = active_channels() * $urandom_range(1, 3);
            if ($urandom_range(4) == 0)
                len = $urandom_range(1, len);
            swap = ($urandom_range(7) == 0) && (len > 1);
            for (int k = 1; k <= len; k++)
            begin
                if (swap && k == len / 2 + 1)
                begin
                    settle();
                    write_reg(REG_NUM_CHANNELS, rand_nch_word());
                end
                push_sample(rand_sample(), k == len);
            end
            left -= len;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = REG_NUM_CHANNELS;
        cfg_bus.data          = '0;
        sample_bus.valid      = 1'b0;
        sample_bus.sample     = '0;
        sample_bus.buffer_end = 1'b0;
        level_bus.ready       = 1'b0;
        meter_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_channel_counts();
        test_frame_restart();
        test_weights();
        test_random_buffers();

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d samples in %0d buffers, %0d level results, %0d writes",
                 n_samples, n_buffers, n_levels, n_writes);
        $display("incl. partial frames, clamped settings, mid-frame count changes");
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
